// ===== design/hashed_lru_buffer_cache_defines.svh =====
// Assertion macros for the buffer cache tag store.
`ifndef HASHED_LRU_BUFFER_CACHE_DEFINES_SVH
`define HASHED_LRU_BUFFER_CACHE_DEFINES_SVH

// Clocked implication, held off while in reset.
`define HLBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but checked during reset as well.
`define HLBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/hlbc_pkg.sv =====
// Shared constants and codes for the buffer cache tag store.
package hlbc_pkg;
  localparam int ENTRIES_DEF = 32;
  localparam int BUCKETS_DEF = 13;
  localparam int BLK_W       = 32;
  localparam int DEV_W       = 8;
  localparam int CNT_W       = 8;
  localparam int PORT_IDX_W  = 5;

  typedef enum logic [1:0] {
    ACT_GET   = 2'd0,
    ACT_REL   = 2'd1,
    ACT_PIN   = 2'd2,
    ACT_UNPIN = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_UNDER  = 2'd2,
    STAT_OVER   = 2'd3
  } status_t;
endpackage

// ===== design/hashed_lru_buffer_cache.sv =====
// Hashed LRU buffer cache tag store: takes one item at a time and returns one result per item.
// Steps, from the accepting edge to the load of the output register: a get runs a byte-wise
// modulo (two small constant residue tables and one compare and subtract per byte) to find
// the home bucket, then a tag and victim scan over all entries, a decision step and the
// hand-over. When an entry is taken from another bucket, a recency renumbering pass over all
// entries comes before the hand-over. A release that drops the count to zero runs a read
// step, the modulo, a renumbering pass and the hand-over. Pin, unpin and other releases run
// a read step and the hand-over, and an out-of-range entry goes straight to the hand-over.
// All per-entry state sits in registers read at a single sequencer index, so the scan counter
// sets the pace. in_ready is high only while the sequencer is idle and no result is waiting
// to be handed over. The output register holds a result until it is taken; a second finished
// result waits in the pending result registers and keeps in_ready low, so a stalled receiver
// also holds back the acceptance of new items.
module hashed_lru_buffer_cache #(
  parameter int ENTRIES = hlbc_pkg::ENTRIES_DEF,
  parameter int BUCKETS = hlbc_pkg::BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [hlbc_pkg::DEV_W-1:0]    device,
  input  logic [hlbc_pkg::BLK_W-1:0]    block_number,
  input  logic [hlbc_pkg::PORT_IDX_W-1:0] entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hlbc_pkg::PORT_IDX_W-1:0] entry_index,
  output logic                          hit,
  output logic                          need_read,
  output logic [1:0]                    status
);
  import hlbc_pkg::*;

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW    = BW + 1;
  localparam int NBYTE = BLK_W / 8;
  localparam int KW    = (NBYTE > 1) ? $clog2(NBYTE) : 1;
  localparam logic [IW-1:0]    LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [KW-1:0]    LAST_K   = KW'(NBYTE - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  // residue of each byte value, and of a remainder shifted up by one byte
  function automatic logic [256*BW-1:0] byte_res_tbl();
    logic [256*BW-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) t[i*BW +: BW] = BW'(i % BUCKETS);
    return t;
  endfunction

  function automatic logic [(1<<BW)*BW-1:0] shift_res_tbl();
    logic [(1<<BW)*BW-1:0] t;
    t = '0;
    for (int i = 0; i < (1 << BW); i++) t[i*BW +: BW] = BW'((i * 256) % BUCKETS);
    return t;
  endfunction

  localparam logic [256*BW-1:0]     BYTE_RES  = byte_res_tbl();
  localparam logic [(1<<BW)*BW-1:0] SHIFT_RES = shift_res_tbl();

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MOD  = 6'b000100,
    S_SCAN = 6'b001000,
    S_DEC  = 6'b010000,
    S_RANK = 6'b100000
  } state_t;
  // S_FIN shares no code with others: encoded via fin flag below
  state_t state;
  logic   fin;

  // per-entry tag state
  logic [DEV_W-1:0] tag_dev [ENTRIES];
  logic [BLK_W-1:0] tag_blk [ENTRIES];
  logic             cvalid  [ENTRIES];
  logic [CNT_W-1:0] refcnt  [ENTRIES];
  logic [BW-1:0]    home    [ENTRIES];
  logic [IW-1:0]    rank    [ENTRIES];

  // latched item
  logic [1:0]       act;
  logic [DEV_W-1:0] dev;
  logic [BLK_W-1:0] blk;
  logic [BW-1:0]    bucket;

  // sequencer and modulo unit
  logic [IW-1:0]    j;
  logic [KW-1:0]    k;
  logic [BW-1:0]    rem;
  logic [BLK_W-1:0] mod_src;
  logic [RW-1:0]    rem_sum, rem_next;

  // scan trackers
  logic             found_ok, hv_ok, ov_ok;
  logic [IW-1:0]    found_idx, hv_idx, ov_idx;
  logic [IW-1:0]    found_rank, hv_rank, ov_rank;
  logic [BW-1:0]    ov_bkt;
  logic [CNT_W-1:0] found_cnt;
  logic             found_val;

  // renumbering target
  logic [IW-1:0]    tgt, tgt_rank;

  // pending result
  logic [PORT_IDX_W-1:0] res_idx;
  logic                  res_hit, res_need;
  logic [1:0]            res_status;

  logic in_acc, is_home, is_match, is_free;

  assign in_ready = (state == S_IDLE) && !fin;
  assign in_acc   = in_valid && in_ready;

  // one byte step of the block number mod BUCKETS, most significant byte first
  assign rem_sum  = {1'b0, SHIFT_RES[rem*BW +: BW]} +
                    {1'b0, BYTE_RES[mod_src[BLK_W-1 -: 8]*BW +: BW]};
  assign rem_next = (rem_sum >= RW'(BUCKETS)) ? rem_sum - RW'(BUCKETS) : rem_sum;

  assign is_home  = (home[j] == bucket);
  assign is_match = is_home && (tag_dev[j] == dev) && (tag_blk[j] == blk);
  assign is_free  = (refcnt[j] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        tag_dev[i] <= '0;
        tag_blk[i] <= '0;
        cvalid[i]  <= 1'b0;
        refcnt[i]  <= '0;
        home[i]    <= BW'(i % BUCKETS);
        rank[i]    <= IW'(i);
      end
    end else begin
      // result slot: hand over when the output register is free
      if (fin && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        entry_index <= res_idx;
        hit         <= res_hit;
        need_read   <= res_need;
        status      <= res_status;
        fin         <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            act        <= action;
            dev        <= device;
            blk        <= block_number;
            res_idx    <= entry;
            res_hit    <= 1'b0;
            res_need   <= 1'b0;
            res_status <= STAT_OK;
            if (action == ACT_GET) begin
              mod_src <= block_number;
              rem     <= '0;
              k       <= '0;
              state   <= S_MOD;
            end else if (32'(entry) >= ENTRIES) begin
              fin <= 1'b1;  // out of range: ignored
            end else begin
              j     <= IW'(entry);
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (act == ACT_PIN) begin
            if (refcnt[j] == CNT_MAX) res_status <= STAT_OVER;
            else refcnt[j] <= refcnt[j] + 1'b1;
            fin   <= 1'b1;
            state <= S_IDLE;
          end else if (is_free) begin
            res_status <= STAT_UNDER;
            fin        <= 1'b1;
            state      <= S_IDLE;
          end else begin
            refcnt[j] <= refcnt[j] - 1'b1;
            if (act == ACT_REL && refcnt[j] == CNT_W'(1)) begin
              // last reference gone: rehome and make most recent
              mod_src  <= tag_blk[j];
              rem      <= '0;
              k        <= '0;
              tgt      <= j;
              tgt_rank <= rank[j];
              state    <= S_MOD;
            end else begin
              fin   <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_MOD: begin
          rem     <= rem_next[BW-1:0];
          mod_src <= mod_src << 8;
          k       <= k + 1'b1;
          if (k == LAST_K) begin
            j <= '0;
            if (act == ACT_GET) begin
              bucket   <= rem_next[BW-1:0];
              found_ok <= 1'b0;
              hv_ok    <= 1'b0;
              ov_ok    <= 1'b0;
              state    <= S_SCAN;
            end else begin
              home[tgt] <= rem_next[BW-1:0];
              state     <= S_RANK;
            end
          end
        end
        S_SCAN: begin
          if (is_match && (!found_ok || rank[j] > found_rank)) begin
            found_ok   <= 1'b1;
            found_idx  <= j;
            found_rank <= rank[j];
            found_cnt  <= refcnt[j];
            found_val  <= cvalid[j];
          end
          if (is_home && is_free && (!hv_ok || rank[j] < hv_rank)) begin
            hv_ok   <= 1'b1;
            hv_idx  <= j;
            hv_rank <= rank[j];
          end
          // other buckets: lowest bucket first, then least recent
          if (!is_home && is_free && (!ov_ok || {home[j], rank[j]} < {ov_bkt, ov_rank})) begin
            ov_ok   <= 1'b1;
            ov_idx  <= j;
            ov_bkt  <= home[j];
            ov_rank <= rank[j];
          end
          j <= j + 1'b1;
          if (j == LAST_IDX) state <= S_DEC;
        end
        S_DEC: begin
          // a steal still has the renumbering pass to run
          if (found_ok || hv_ok || !ov_ok) begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_RANK;
          end
          if (found_ok) begin
            res_idx <= PORT_IDX_W'(found_idx);
            res_hit <= 1'b1;
            if (found_cnt == CNT_MAX) begin
              res_status <= STAT_OVER;
            end else begin
              refcnt[found_idx] <= found_cnt + 1'b1;
              cvalid[found_idx] <= 1'b1;
              res_need          <= !found_val;
            end
          end else if (hv_ok) begin
            res_idx         <= PORT_IDX_W'(hv_idx);
            res_need        <= 1'b1;
            tag_dev[hv_idx] <= dev;
            tag_blk[hv_idx] <= blk;
            refcnt[hv_idx]  <= CNT_W'(1);
            cvalid[hv_idx]  <= 1'b1;
          end else if (ov_ok) begin
            res_idx         <= PORT_IDX_W'(ov_idx);
            res_need        <= 1'b1;
            tag_dev[ov_idx] <= dev;
            tag_blk[ov_idx] <= blk;
            refcnt[ov_idx]  <= CNT_W'(1);
            cvalid[ov_idx]  <= 1'b1;
            home[ov_idx]    <= bucket;
            tgt             <= ov_idx;
            tgt_rank        <= ov_rank;
            j               <= '0;
          end else begin
            res_idx    <= '0;
            res_status <= STAT_NOFREE;
          end
        end
        S_RANK: begin
          if (j == tgt) rank[j] <= LAST_IDX;
          else if (rank[j] > tgt_rank) rank[j] <= rank[j] - 1'b1;
          j <= j + 1'b1;
          if (j == LAST_IDX) begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "hashed_lru_buffer_cache_defines.svh"
  `HLBC_ASSERT(a_busy_after_accept, in_acc |=> !in_ready, "accepted item left block ready")
  `HLBC_ASSERT(a_nofree_clean,
    (out_valid && status == STAT_NOFREE) |-> (entry_index == '0 && !hit && !need_read),
    "no-free result carries entry data")
  `HLBC_ASSERT(a_hit_no_under, (out_valid && hit) |-> (status != STAT_UNDER),
    "hit reported with underflow")
  `HLBC_ASSERT_ALWAYS(a_fin_idle, fin |-> (state == S_IDLE), "result pending while busy")
endmodule

// ===== sim/hashed_lru_buffer_cache_checker.sv =====
// Checker for the buffer cache tag store: predicts each result and compares it.
`timescale 1ns / 1ps
module hashed_lru_buffer_cache_checker #(
  parameter int ENTRIES = hlbc_pkg::ENTRIES_DEF,
  parameter int BUCKETS = hlbc_pkg::BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [4:0]  entry,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  entry_index,
  input  logic        hit,
  input  logic        need_read,
  input  logic [1:0]  status,
  output int          failures,
  output int          pending
);
  import hlbc_pkg::*;

  typedef struct packed {
    logic [4:0] idx;
    logic       hit;
    logic       need;
    status_t    stat;
  } lookup_t;

  logic [7:0]  tdev  [ENTRIES];
  logic [31:0] tblk  [ENTRIES];
  logic        valid_q [ENTRIES];
  logic [7:0]  refs  [ENTRIES];
  int          bucket_of [ENTRIES];
  int          rank  [ENTRIES];
  lookup_t     awaited[$];

  function automatic void promote(int e);
    int r;
    r = rank[e];
    for (int j = 0; j < ENTRIES; j++)
      if (rank[j] > r) rank[j]--;
    rank[e] = ENTRIES - 1;
  endfunction

  function automatic int oldest_free(int b);
    int best;
    best = ENTRIES;
    for (int j = 0; j < ENTRIES; j++)
      if (bucket_of[j] == b && refs[j] == 0 && (best == ENTRIES || rank[j] < rank[best]))
        best = j;
    return best;
  endfunction

  function automatic lookup_t lookup(action_t act, logic [7:0] dv, logic [31:0] bn,
                                     logic [4:0] e);
    lookup_t r;
    int home, found, victim;
    r = '{idx: 0, hit: 0, need: 0, stat: STAT_OK};
    if (act == ACT_GET) begin
      home = int'(bn % BUCKETS);
      found = ENTRIES;
      for (int j = 0; j < ENTRIES; j++)
        if (bucket_of[j] == home && tdev[j] == dv && tblk[j] == bn &&
            (found == ENTRIES || rank[j] > rank[found]))
          found = j;
      if (found < ENTRIES) begin
        r.idx = 5'(found);
        r.hit = 1;
        if (refs[found] == 8'hff) r.stat = STAT_OVER;
        else begin
          refs[found]++;
          r.need = !valid_q[found];
          valid_q[found] = 1;
        end
      end else begin
        victim = oldest_free(home);
        if (victim == ENTRIES) begin
          for (int b = 0; b < BUCKETS && victim == ENTRIES; b++)
            if (b != home) victim = oldest_free(b);
          if (victim < ENTRIES) begin
            bucket_of[victim] = home;
            promote(victim);
          end
        end
        if (victim == ENTRIES) r.stat = STAT_NOFREE;
        else begin
          r.idx = 5'(victim);
          tdev[victim] = dv;
          tblk[victim] = bn;
          refs[victim] = 1;
          valid_q[victim] = 1;
          r.need = 1;
        end
      end
    end else begin
      r.idx = e;
      if (e < ENTRIES) begin
        if (act == ACT_PIN) begin
          if (refs[e] == 8'hff) r.stat = STAT_OVER;
          else refs[e]++;
        end else if (refs[e] == 0) begin
          r.stat = STAT_UNDER;
        end else begin
          refs[e]--;
          // only a release to zero rehomes and promotes
          if (act == ACT_REL && refs[e] == 0) begin
            bucket_of[e] = int'(tblk[e] % BUCKETS);
            promote(e);
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      failures <= 0;
      pending  <= 0;
      awaited.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        tdev[i] = 0; tblk[i] = 0; valid_q[i] = 0; refs[i] = 0;
        bucket_of[i] = i % BUCKETS;
        rank[i] = i;
      end
    end else begin
      if (in_valid && in_ready)
        awaited.push_back(lookup(action_t'(action), device, block_number, entry));
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result idx=%0d hit=%0d need=%0d st=%0d", $time,
                   entry_index, hit, need_read, status);
          failures <= failures + 1;
        end else begin
          want = awaited.pop_front();
          if (want.idx !== entry_index || want.hit !== hit || want.need !== need_read ||
              want.stat !== status) begin
            $display("%0t: expected idx=%0d hit=%0d need=%0d st=%0d, got %0d %0d %0d %0d",
                     $time, want.idx, want.hit, want.need, want.stat,
                     entry_index, hit, need_read, status);
            failures <= failures + 1;
          end
        end
      end
      pending <= awaited.size();
    end
  end
endmodule

// ===== sim/hashed_lru_buffer_cache_test.sv =====
// Top of the buffer cache tag store testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module hashed_lru_buffer_cache_test;
  import hlbc_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [1:0]  action, status;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [4:0]  entry, entry_index;
  logic        hit, need_read;
  int          failures, pending;
  int          cycles;
  int          idle_pct, stall_pct;
  logic [31:0] recent_blk [8];

  hashed_lru_buffer_cache dut (.*);
  hashed_lru_buffer_cache_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: reports a mismatch and stops if the run outlasts its limit, set with a wide margin for heavy stalls
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 900000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: stall percentage set by the phase
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // one item: optional gap, then hold valid until accepted
  task automatic send(action_t act, logic [7:0] dv, logic [31:0] bn, logic [4:0] e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    device <= dv;
    block_number <= bn;
    entry <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every result has been taken
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic send_random();
    int pick;
    logic [31:0] bn;
    pick = $urandom_range(99);
    // mostly reuse eight stored block numbers so hits and recycling are common
    if ($urandom_range(3) == 0) bn = $urandom();
    else bn = recent_blk[3'($urandom_range(7))];
    if (pick < 45) send(ACT_GET, 8'($urandom_range(3)) ^ ($urandom_range(9) == 0 ? 8'hff : 8'h00),
                        bn, 5'($urandom()));
    else if (pick < 75) send(ACT_REL, 8'($urandom()), $urandom(), 5'($urandom()));
    else if (pick < 88) send(ACT_PIN, 8'($urandom()), $urandom(), 5'($urandom()));
    else send(ACT_UNPIN, 8'($urandom()), $urandom(), 5'($urandom()));
  endtask

  initial begin
    rst = 1;
    in_valid = 0; action = ACT_GET; device = 0; block_number = 0; entry = 0;
    idle_pct = 0; stall_pct = 0;
    for (int i = 0; i < 8; i++) recent_blk[i] = $urandom_range(40);
    recent_blk[7] = 32'hffff_ffff;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset tags are device 0 block 0, so the first get hits
    send(ACT_GET, 8'h00, 32'h0, 5'd0);
    send(ACT_GET, 8'hff, 32'hffff_ffff, 5'd31);
    send(ACT_REL, 8'h00, 32'h0, 5'd0);          // underflow: the first get took entry 26
    send(ACT_UNPIN, 8'h00, 32'h0, 5'd5);        // underflow
    send(ACT_REL, 8'h00, 32'h0, 5'd31);         // underflow
    send(ACT_PIN, 8'hff, 32'hffff_ffff, 5'd31);
    send(ACT_UNPIN, 8'h00, 32'h0, 5'd31);       // unpin to zero, no move
    // pin one entry to its ceiling, then overflow it
    for (int i = 0; i < 255; i++) send(ACT_PIN, 8'h00, 32'h0, 5'd3);
    send(ACT_PIN, 8'h00, 32'h0, 5'd3);
    send(ACT_GET, 8'h00, 32'd3, 5'd0);          // miss, recycle in home bucket
    // exhaust free entries, forcing steals then no-free-buffer
    for (int i = 0; i < 34; i++) send(ACT_GET, 8'h5a, 32'(i * 13 + 100), 5'd0);
    for (int i = 0; i < 32; i++) send(ACT_REL, 8'h00, 32'h0, 5'(i));
    // pressure: wait for every result before going on
    drain();
    for (int i = 0; i < 256; i++) send(ACT_UNPIN, 8'h00, 32'h0, 5'd3);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int i = 0; i < 128; i++) send_random();
    end

    drain();
    repeat (200) @(posedge clk);
    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/hlbc_pkg.sv
design/hashed_lru_buffer_cache.sv
sim/hashed_lru_buffer_cache_checker.sv
sim/hashed_lru_buffer_cache_test.sv
